// ----- src/cdps_pkg.sv -----
// ----------------------------------------------------------------------------
// cdps_pkg
// Shared constants and types for the counter delta per-mille share block.
// ----------------------------------------------------------------------------
`default_nettype none

package cdps_pkg;

  // Number of counters in one set
  localparam int NUM_STATES = 10;

  // Field widths
  localparam int CNT_W   = 64;
  localparam int POS_W   = 6;
  localparam int SHARE_W = 10;

  // Index width into the per-state arrays
  localparam int IDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

  // Divider step counter width (one quotient bit per step)
  localparam int STEP_W = $clog2(CNT_W);

  // Position of the last counter in a set
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_STATES - 1);

  // Arithmetic constants
  localparam logic [SHARE_W-1:0] SHARE_SCALE = 10'd1000;
  localparam logic [CNT_W-1:0]   SIGNED_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  // Sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_DIFF = 10'b00_0000_0010,
    ST_FIX  = 10'b00_0000_0100,
    ST_ACC  = 10'b00_0000_1000,
    ST_TOT  = 10'b00_0001_0000,
    ST_MUL  = 10'b00_0010_0000,
    ST_ADD  = 10'b00_0100_0000,
    ST_DIV  = 10'b00_1000_0000,
    ST_SAT  = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_t;

endpackage

`default_nettype wire

// ----- src/counter_delta_permille_shares_core.sv -----
// A counter that does not close a set steps through accept, diff, wrap fix and
// accumulate; the closing counter then prepares the total and computes one
// share per state before the block is ready again, each held while stalled.
// Each share runs multiply, add, the shared radix-2 restoring divider (one
// quotient bit per cycle, 64 steps), clamp and output.
// Reset (rst_n low, synchronous) clears stored counters, total and position.
// ----------------------------------------------------------------------------
// counter_delta_permille_shares_core
// Per-set counter deltas with wrap handling, followed by per-mille shares of
// the total change computed one at a time on a shared serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_delta_permille_shares_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [cdps_pkg::CNT_W-1:0]        in_counter_value,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [cdps_pkg::POS_W-1:0]             out_state_index,
  output logic [cdps_pkg::SHARE_W-1:0]           out_share_permille,
  output logic                                   out_last_of_run
);

  // Sequencer and datapath registers
  cdps_pkg::state_t                  state_r, state_nxt;
  logic [cdps_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [cdps_pkg::POS_W-1:0]        sel_r, sel_nxt;
  logic [cdps_pkg::STEP_W-1:0]       cnt_r, cnt_nxt;
  logic [cdps_pkg::CNT_W-1:0]        now_r, now_nxt;
  logic [cdps_pkg::CNT_W-1:0]        diff_r, diff_nxt;
  logic [cdps_pkg::CNT_W-1:0]        total_r, total_nxt;
  logic [cdps_pkg::CNT_W-1:0]        divisor_r, divisor_nxt;
  logic [cdps_pkg::CNT_W-1:0]        prod_r, prod_nxt;
  logic [cdps_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic [cdps_pkg::CNT_W-1:0]        num_r, num_nxt;
  logic [cdps_pkg::SHARE_W-1:0]      share_r, share_nxt;

  // Per-state storage
  logic [cdps_pkg::CNT_W-1:0]        prev_r  [cdps_pkg::NUM_STATES];
  logic [cdps_pkg::CNT_W-1:0]        delta_r [cdps_pkg::NUM_STATES];

  logic [cdps_pkg::IDX_W-1:0]        pos_idx;
  logic [cdps_pkg::IDX_W-1:0]        sel_idx;

  // Divider step
  logic [cdps_pkg::CNT_W:0]          rem_sh;
  logic [cdps_pkg::CNT_W:0]          trial;

  assign pos_idx = pos_r[cdps_pkg::IDX_W-1:0];
  assign sel_idx = sel_r[cdps_pkg::IDX_W-1:0];

  assign rem_sh = {rem_r, num_r[cdps_pkg::CNT_W-1]};
  assign trial  = rem_sh - {1'b0, divisor_r};

  // Next-state and datapath logic
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    sel_nxt     = sel_r;
    cnt_nxt     = cnt_r;
    now_nxt     = now_r;
    diff_nxt    = diff_r;
    total_nxt   = total_r;
    divisor_nxt = divisor_r;
    prod_nxt    = prod_r;
    rem_nxt     = rem_r;
    num_nxt     = num_r;
    share_nxt   = share_r;

    case (state_r)
      cdps_pkg::ST_IDLE: begin
        if (in_valid) begin
          now_nxt   = in_counter_value;
          state_nxt = cdps_pkg::ST_DIFF;
        end
      end
      cdps_pkg::ST_DIFF: begin
        diff_nxt  = now_r - prev_r[pos_idx];
        state_nxt = cdps_pkg::ST_FIX;
      end
      cdps_pkg::ST_FIX: begin
        // Negative change: counter wrapped, add the signed maximum
        if (diff_r[cdps_pkg::CNT_W-1]) begin
          diff_nxt = diff_r + cdps_pkg::SIGNED_MAX;
        end
        state_nxt = cdps_pkg::ST_ACC;
      end
      cdps_pkg::ST_ACC: begin
        total_nxt = total_r + diff_r;
        if (pos_r == cdps_pkg::LAST_POS) begin
          state_nxt = cdps_pkg::ST_TOT;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = cdps_pkg::ST_IDLE;
        end
      end
      cdps_pkg::ST_TOT: begin
        // Zero total divides by one
        divisor_nxt = (total_r == '0) ? cdps_pkg::CNT_W'(1) : total_r;
        sel_nxt     = '0;
        state_nxt   = cdps_pkg::ST_MUL;
      end
      cdps_pkg::ST_MUL: begin
        prod_nxt  = delta_r[sel_idx] * cdps_pkg::SHARE_SCALE;
        state_nxt = cdps_pkg::ST_ADD;
      end
      cdps_pkg::ST_ADD: begin
        // Rounding bias, then load the divider
        num_nxt   = prod_r + (divisor_r >> 1);
        rem_nxt   = '0;
        cnt_nxt   = '1;
        state_nxt = cdps_pkg::ST_DIV;
      end
      cdps_pkg::ST_DIV: begin
        // Restoring step: quotient bits shift into num_r
        if (!trial[cdps_pkg::CNT_W]) begin
          rem_nxt = trial[cdps_pkg::CNT_W-1:0];
          num_nxt = {num_r[cdps_pkg::CNT_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[cdps_pkg::CNT_W-1:0];
          num_nxt = {num_r[cdps_pkg::CNT_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = cdps_pkg::ST_SAT;
        end
      end
      cdps_pkg::ST_SAT: begin
        share_nxt = (num_r > cdps_pkg::CNT_W'(cdps_pkg::SHARE_SCALE)) ?
                    cdps_pkg::SHARE_SCALE : num_r[cdps_pkg::SHARE_W-1:0];
        state_nxt = cdps_pkg::ST_OUT;
      end
      cdps_pkg::ST_OUT: begin
        if (out_ready) begin
          if (sel_r == cdps_pkg::LAST_POS) begin
            total_nxt = '0;
            pos_nxt   = '0;
            state_nxt = cdps_pkg::ST_IDLE;
          end else begin
            sel_nxt   = sel_r + 1'b1;
            state_nxt = cdps_pkg::ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = cdps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdps_pkg::ST_IDLE;
      pos_r   <= '0;
      sel_r   <= '0;
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    diff_r    <= diff_nxt;
    divisor_r <= divisor_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    num_r     <= num_nxt;
    share_r   <= share_nxt;
  end

  // Previous counter values, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cdps_pkg::NUM_STATES; i++) begin
        prev_r[i] <= '0;
      end
    end else if (state_r == cdps_pkg::ST_ACC) begin
      prev_r[pos_idx] <= now_r;
    end
  end

  // Stored deltas, always written before they are read
  always_ff @(posedge clk) begin
    if (state_r == cdps_pkg::ST_ACC) begin
      delta_r[pos_idx] <= diff_r;
    end
  end

  // Ports
  assign in_ready           = (state_r == cdps_pkg::ST_IDLE);
  assign out_valid          = (state_r == cdps_pkg::ST_OUT);
  assign out_state_index    = sel_r;
  assign out_share_permille = share_r;
  assign out_last_of_run    = (sel_r == cdps_pkg::LAST_POS);

endmodule

`default_nettype wire

// ----- src/cdps_checker.sv -----
// ----------------------------------------------------------------------------
// cdps_checker
// Port-level checks for the counter delta per-mille share block.
// ----------------------------------------------------------------------------
`default_nettype none

module cdps_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [cdps_pkg::POS_W-1:0]      out_state_index,
  input wire logic [cdps_pkg::SHARE_W-1:0]    out_share_permille,
  input wire logic                            out_last_of_run
);

  // Shares never exceed the saturation level
  a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_share_permille <= cdps_pkg::SHARE_SCALE))
    else $error("share above saturation");

  // Last flag marks exactly the final state of a set
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_run == (out_state_index == cdps_pkg::LAST_POS)))
    else $error("last flag mismatch");

  // Input is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // An input transaction is followed by a busy cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_state_index) &&
                                   $stable(out_share_permille)))
    else $error("stalled result changed");

endmodule

bind counter_delta_permille_shares_core cdps_checker u_cdps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_state_index    (out_state_index),
  .out_share_permille (out_share_permille),
  .out_last_of_run    (out_last_of_run)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for counter_delta_permille_shares_core. Feeds sets of
// running 64-bit counters (directed extremes, then random sets mixing small
// steps, unchanged counters, wraps and full-range values), tracks per-state
// deltas and the set total in a local model, and checks every per-mille share
// transaction in order. Runs through idle and back-pressure phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int SETS_PER_PHASE = 6;

  // One expected share transaction
  typedef struct packed {
    logic [cdps_pkg::POS_W-1:0]   idx;
    logic [cdps_pkg::SHARE_W-1:0] permille;
    logic                         last;
  } share_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [cdps_pkg::CNT_W-1:0]   in_counter_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [cdps_pkg::POS_W-1:0]   out_state_index;
  logic [cdps_pkg::SHARE_W-1:0] out_share_permille;
  logic                         out_last_of_run;

  // Stimulus and expectation stores
  logic [cdps_pkg::CNT_W-1:0] pending_counters[$];
  share_t                     expected_shares[$];

  // Local copy of the block state
  logic [cdps_pkg::CNT_W-1:0] last_seen[cdps_pkg::NUM_STATES];
  logic [cdps_pkg::CNT_W-1:0] state_delta[cdps_pkg::NUM_STATES];
  logic [cdps_pkg::CNT_W-1:0] delta_sum;
  int unsigned                next_slot;

  // Generator view of the counters, ahead of the block
  logic [cdps_pkg::CNT_W-1:0] gen_counter[cdps_pkg::NUM_STATES];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        in_taken;
  bit          failed;

  counter_delta_permille_shares_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_counter_value  (in_counter_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_state_index   (out_state_index),
    .out_share_permille(out_share_permille),
    .out_last_of_run   (out_last_of_run)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rounded per-mille share, 64-bit modular, clamped at full scale
  function automatic logic [cdps_pkg::SHARE_W-1:0] share_permille_of(
      input logic [cdps_pkg::CNT_W-1:0] delta,
      input logic [cdps_pkg::CNT_W-1:0] total);
    logic [cdps_pkg::CNT_W-1:0] num;
    logic [cdps_pkg::CNT_W-1:0] quo;
    num = delta * 64'd1000 + total / 64'd2;
    quo = num / total;
    if (quo > 64'd1000) quo = 64'd1000;
    return quo[cdps_pkg::SHARE_W-1:0];
  endfunction

  // Fold one accepted counter into the model; a closing counter queues shares
  task automatic absorb_counter(input logic [cdps_pkg::CNT_W-1:0] now);
    logic [cdps_pkg::CNT_W-1:0] change;
    logic [cdps_pkg::CNT_W-1:0] total;
    int unsigned                slot;
    share_t                     sh;
    slot = (next_slot >= cdps_pkg::NUM_STATES) ? 0 : next_slot;
    change = now - last_seen[slot];
    // Counter wrap: negative change measured against the signed maximum
    if (change[cdps_pkg::CNT_W-1]) change = cdps_pkg::SIGNED_MAX - last_seen[slot] + now;
    state_delta[slot] = change;
    last_seen[slot]   = now;
    delta_sum         = delta_sum + change;
    if (slot + 1 < cdps_pkg::NUM_STATES) begin
      next_slot = slot + 1;
    end else begin
      total = (delta_sum == '0) ? 64'd1 : delta_sum;
      for (int i = 0; i < cdps_pkg::NUM_STATES; i++) begin
        sh.idx      = cdps_pkg::POS_W'(i);
        sh.permille = share_permille_of(state_delta[i], total);
        sh.last     = (i == cdps_pkg::NUM_STATES - 1);
        expected_shares.push_back(sh);
      end
      delta_sum = '0;
      next_slot = 0;
    end
  endtask

  function automatic logic [cdps_pkg::CNT_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One random set: tick growth, unchanged counters, wraps and noise
  task automatic queue_random_set();
    int unsigned                flavor;
    int unsigned                pick;
    logic [cdps_pkg::CNT_W-1:0] v;
    flavor = $urandom_range(99);
    for (int i = 0; i < cdps_pkg::NUM_STATES; i++) begin
      pick = (flavor < 10) ? 50 : (flavor < 20) ? 75 : $urandom_range(99);
      if (pick < 45) begin
        v = gen_counter[i] + 64'($urandom_range(5000));
      end else if (pick < 60) begin
        v = gen_counter[i];
      end else if (pick < 70) begin
        v = gen_counter[i] - 64'($urandom_range(1, 100));
      end else if (pick < 88) begin
        v = rand64();
      end else begin
        case ($urandom_range(3))
          0:       v = '0;
          1:       v = '1;
          2:       v = 64'h8000_0000_0000_0000;
          default: v = cdps_pkg::SIGNED_MAX;
        endcase
      end
      gen_counter[i] = v;
      pending_counters.push_back(v);
    end
  endtask

  // Driver: inputs change on the falling edge
  always @(negedge clk) begin : drive_blk
    logic                       nxt_valid;
    logic [cdps_pkg::CNT_W-1:0] nxt_value;
    nxt_valid = in_valid;
    nxt_value = in_counter_value;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_counters.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_value = pending_counters.pop_front();
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_valid         <= nxt_valid;
    in_counter_value <= nxt_value;
    out_ready        <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: sample both channels on the rising edge
  always @(posedge clk) begin : monitor_blk
    share_t exp_sh;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) absorb_counter(in_counter_value);
      if (out_valid && out_ready) begin
        if (expected_shares.size() == 0) begin
          $error("unexpected share transaction: state_index %0d share_permille %0d",
                 out_state_index, out_share_permille);
          failed = 1'b1;
        end else begin
          exp_sh = expected_shares.pop_front();
          if (out_state_index !== exp_sh.idx) begin
            $error("state_index expected %0d actual %0d", exp_sh.idx, out_state_index);
            failed = 1'b1;
          end
          if (out_share_permille !== exp_sh.permille) begin
            $error("share_permille expected %0d actual %0d", exp_sh.permille,
                   out_share_permille);
            failed = 1'b1;
          end
          if (out_last_of_run !== exp_sh.last) begin
            $error("last_of_run expected %0d actual %0d", exp_sh.last, out_last_of_run);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_counter_value = '0;
    out_ready        = 1'b0;
    in_taken         = 1'b0;
    failed           = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    delta_sum        = '0;
    next_slot        = 0;
    for (int i = 0; i < cdps_pkg::NUM_STATES; i++) begin
      last_seen[i]   = '0;
      state_delta[i] = '0;
      gen_counter[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Zero total: nothing moved since reset
    for (int i = 0; i < cdps_pkg::NUM_STATES; i++) pending_counters.push_back('0);

    // Extremes: wraps from zero, max positive step, tiny and product overflow
    pending_counters.push_back('1);
    pending_counters.push_back(64'h8000_0000_0000_0000);
    pending_counters.push_back(cdps_pkg::SIGNED_MAX);
    pending_counters.push_back(64'd1);
    pending_counters.push_back(64'd0);
    pending_counters.push_back(64'd1000);
    pending_counters.push_back(64'h0040_0000_0000_0000);
    pending_counters.push_back(64'hAAAA_5555_AAAA_5555);
    pending_counters.push_back(64'h5555_AAAA_5555_AAAA);
    pending_counters.push_back(64'hFFFF_FFFF_0000_0000);
    gen_counter = '{'1, 64'h8000_0000_0000_0000, cdps_pkg::SIGNED_MAX, 64'd1, 64'd0,
                    64'd1000, 64'h0040_0000_0000_0000, 64'hAAAA_5555_AAAA_5555,
                    64'h5555_AAAA_5555_AAAA, 64'hFFFF_FFFF_0000_0000};

    // Random sets under each flow-control phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int s = 0; s < SETS_PER_PHASE; s++) queue_random_set();
      wait (pending_counters.size() == 0 && !in_valid && expected_shares.size() == 0);
    end

    // Drain and let any stray transaction show up
    repeat (200) @(posedge clk);
    if (!failed && expected_shares.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
